// ----- hdl/amsp_pkg.sv -----
// ----------------------------------------------------------------------------
// amsp_pkg
// Shared types and constants of the access map stride prefetcher.
// ----------------------------------------------------------------------------
package amsp_pkg;

    localparam int PAGE_ENTRIES_DEF = 64;
    localparam int ADDR_W           = 48;
    localparam int TAG_W            = 36;
    localparam int STAMP_W          = 48;
    localparam int LINE_W           = 6;
    localparam int MAP_W            = 64;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 5;

    localparam logic [CFG_IDX_W-1:0]  CFG_DEGREE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_MAX_STRIDE = 2'd1;
    localparam logic [CFG_DATA_W-1:0] DEGREE_RESET   = 5'd2;
    localparam logic [CFG_DATA_W-1:0] STRIDE_RESET   = 5'd16;
    localparam logic [CFG_DATA_W-1:0] DEGREE_CAP     = 5'd16;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] last_use;
        logic [MAP_W-1:0]   accessed;
        logic [MAP_W-1:0]   prefetched;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

// ----- hdl/amsp_table.sv -----
// ----------------------------------------------------------------------------
// amsp_table
// Page entry memory with one read and one write port and per-entry valid bits.
// ----------------------------------------------------------------------------
module amsp_table #(
    parameter int ENTRIES = amsp_pkg::PAGE_ENTRIES_DEF,
    parameter int IW      = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IW-1:0]        rd_addr,
    output amsp_pkg::entry_t     rd_data,
    input  logic                 wr_en,
    input  logic [IW-1:0]        wr_addr,
    input  amsp_pkg::entry_t     wr_data
);

    amsp_pkg::entry_t mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    amsp_pkg::entry_t   rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr] && !(wr_en && wr_addr == rd_addr)
                            ? 1'b1 : valid_reg[rd_addr];
        end
    end

    // An entry never written reads as all zero, as after reset.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hdl/access_map_stride_prefetcher.sv -----
// ----------------------------------------------------------------------------
// access_map_stride_prefetcher
// Page access map prefetcher issuing stride prefetches on each access.
// ----------------------------------------------------------------------------
// Channel  Signals                                   Direction
// input    in_valid/in_ready, access_address,        request in
//          cycle_stamp
// output   out_valid/out_ready, prefetch_address,    request out
//          backward, last
// config   cfg_valid/cfg_ready, cfg_index, cfg_data  register write in
//
// An access runs the tag search, which reads up to PAGE_ENTRIES entries of
// the table memory, one per cycle, then the stride scan over strides from 1
// up to max_stride in each direction, one stride per cycle, and then writes
// the entry back. The scan and the write-back pause while the output register
// is full. No clearing pass follows reset; valid bits stand in for it.
module access_map_stride_prefetcher #(
    parameter int PAGE_ENTRIES = amsp_pkg::PAGE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [amsp_pkg::ADDR_W-1:0]       access_address,
    input  logic [amsp_pkg::STAMP_W-1:0]      cycle_stamp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [amsp_pkg::ADDR_W-1:0]       prefetch_address,
    output logic                              backward,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [amsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [amsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(PAGE_ENTRIES - 1);

    amsp_pkg::state_t state_reg, state_next;

    logic [amsp_pkg::CFG_DATA_W-1:0] degree_reg, max_stride_reg;

    logic [IW-1:0]                   cnt_reg, cnt_next;
    logic [IW-1:0]                   ent_reg, ent_next;
    logic [IW-1:0]                   min_idx_reg, min_idx_next;
    logic [amsp_pkg::STAMP_W-1:0]    min_last_reg, min_last_next;
    logic [amsp_pkg::TAG_W-1:0]      page_reg, page_next;
    logic [amsp_pkg::LINE_W-1:0]     line_reg, line_next;
    logic [amsp_pkg::STAMP_W-1:0]    stamp_reg, stamp_next;
    logic [amsp_pkg::MAP_W-1:0]      acc_reg, acc_next;
    logic [amsp_pkg::MAP_W-1:0]      pf_reg, pf_next;
    logic                            dir_reg, dir_next;
    logic [5:0]                      s_reg, s_next;
    logic [4:0]                      issued_reg, issued_next;

    logic                            pend_valid_reg, pend_valid_next;
    logic [amsp_pkg::ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic                            pend_back_reg, pend_back_next;

    logic                            out_valid_reg, out_valid_next;
    logic [amsp_pkg::ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic                            out_back_reg, out_back_next;
    logic                            out_last_reg, out_last_next;

    logic [IW-1:0]                   rd_addr;
    amsp_pkg::entry_t                rd_data;
    logic                            wr_en;
    amsp_pkg::entry_t                wr_data;

    logic [amsp_pkg::MAP_W-1:0]      line_bit;
    logic [4:0]                      limit;
    logic                            out_free;
    logic [7:0]                      ln8, s8, near8, far8, tgt8;
    logic                            stop;

    amsp_table #(
        .ENTRIES (PAGE_ENTRIES),
        .IW      (IW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (ent_reg),
        .wr_data (wr_data)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == amsp_pkg::ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign prefetch_address = out_addr_reg;
    assign backward         = out_back_reg;
    assign last             = out_last_reg;

    assign line_bit = amsp_pkg::MAP_W'(1) << line_reg;
    assign limit    = (degree_reg > amsp_pkg::DEGREE_CAP) ? amsp_pkg::DEGREE_CAP : degree_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign wr_data.tag        = page_reg;
    assign wr_data.last_use   = stamp_reg;
    assign wr_data.accessed   = acc_reg;
    assign wr_data.prefetched = pf_reg;

    // Stride arithmetic in eight signed bits: a negative value has bit 7 set,
    // a value past the page edge has bit 6 set.
    assign ln8 = {2'b00, line_reg};
    assign s8  = {2'b00, s_reg};
    always_comb
    begin
        if (!dir_reg)
        begin
            near8 = ln8 - s8;
            far8  = ln8 - (s8 << 1);
            tgt8  = ln8 + s8;
        end
        else
        begin
            near8 = ln8 + s8;
            far8  = ln8 + (s8 << 1);
            tgt8  = ln8 - s8;
        end
    end

    assign stop = (s_reg > {1'b0, max_stride_reg}) || far8[7] || far8[6]
                  || tgt8[7] || tgt8[6] || (issued_reg >= limit);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ent_next        = ent_reg;
        min_idx_next    = min_idx_reg;
        min_last_next   = min_last_reg;
        page_next       = page_reg;
        line_next       = line_reg;
        stamp_next      = stamp_reg;
        acc_next        = acc_reg;
        pf_next         = pf_reg;
        dir_next        = dir_reg;
        s_next          = s_reg;
        issued_next     = issued_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_back_next  = pend_back_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_back_next   = out_back_reg;
        out_last_next   = out_last_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;

        unique case (state_reg)
            amsp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    page_next  = access_address[amsp_pkg::ADDR_W-1:12];
                    line_next  = access_address[11:6];
                    stamp_next = cycle_stamp;
                    cnt_next   = '0;
                    state_next = amsp_pkg::ST_SEARCH;
                end
            end

            amsp_pkg::ST_SEARCH:
            begin
                // rd_data holds entry cnt_reg; the next entry is read meanwhile.
                rd_addr = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + IW'(1);
                dir_next    = 1'b0;
                s_next      = 6'd1;
                issued_next = '0;
                if (rd_data.tag == page_reg)
                begin
                    ent_next   = cnt_reg;
                    acc_next   = rd_data.accessed | line_bit;
                    pf_next    = rd_data.prefetched;
                    state_next = amsp_pkg::ST_SCAN;
                end
                else
                begin
                    if (cnt_reg == '0 || rd_data.last_use < min_last_reg)
                    begin
                        min_last_next = rd_data.last_use;
                        min_idx_next  = cnt_reg;
                    end
                    if (cnt_reg == LAST_IDX)
                    begin
                        ent_next   = min_idx_next;
                        acc_next   = line_bit;
                        pf_next    = '0;
                        state_next = amsp_pkg::ST_SCAN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end

            amsp_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    if (stop)
                    begin
                        if (!dir_reg)
                        begin
                            dir_next    = 1'b1;
                            s_next      = 6'd1;
                            issued_next = '0;
                        end
                        else
                        begin
                            state_next = amsp_pkg::ST_WRITE;
                        end
                    end
                    else
                    begin
                        s_next = s_reg + 6'd1;
                        if (!(acc_reg[tgt8[5:0]] || pf_reg[tgt8[5:0]])
                            && acc_reg[near8[5:0]] && acc_reg[far8[5:0]])
                        begin
                            // The held request is released once a later one exists.
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_addr_next  = pend_addr_reg;
                                out_back_next  = pend_back_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_addr_next  = {page_reg, tgt8[5:0], 6'b000000};
                            pend_back_next  = dir_reg;
                            pf_next         = pf_reg | (amsp_pkg::MAP_W'(1) << tgt8[5:0]);
                            issued_next     = issued_reg + 5'd1;
                        end
                    end
                end
            end

            amsp_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_addr_next   = pend_addr_reg;
                        out_back_next   = pend_back_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    wr_en      = 1'b1;
                    state_next = amsp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = amsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= amsp_pkg::ST_IDLE;
            degree_reg     <= amsp_pkg::DEGREE_RESET;
            max_stride_reg <= amsp_pkg::STRIDE_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            dir_reg        <= 1'b0;
            s_reg          <= 6'd1;
            issued_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            dir_reg        <= dir_next;
            s_reg          <= s_next;
            issued_reg     <= issued_next;
            if (cfg_valid)
            begin
                if (cfg_index == amsp_pkg::CFG_DEGREE)
                begin
                    degree_reg <= cfg_data;
                end
                else if (cfg_index == amsp_pkg::CFG_MAX_STRIDE)
                begin
                    max_stride_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg       <= ent_next;
        min_idx_reg   <= min_idx_next;
        min_last_reg  <= min_last_next;
        page_reg      <= page_next;
        line_reg      <= line_next;
        stamp_reg     <= stamp_next;
        acc_reg       <= acc_next;
        pf_reg        <= pf_next;
        pend_addr_reg <= pend_addr_next;
        pend_back_reg <= pend_back_next;
        out_addr_reg  <= out_addr_next;
        out_back_reg  <= out_back_next;
        out_last_reg  <= out_last_next;
    end

endmodule
